[design/tbc_pkg.sv]
package tbc_pkg;

  // Fraction bits of a logarithm and of the Q30 mantissa that is squared.
  localparam int FRAC_W  = 32;
  localparam int MANT_FB = 30;

  // Widths of the configuration and of the quantities along the datapath.
  localparam int BETA_W   = 16;
  localparam int REF_W    = 22;
  localparam int TREF_W   = 15;
  localparam int RES_W    = 16;
  localparam int TEMP_W   = 18;
  localparam int CFG_W    = 22;
  localparam int DMAG_W   = 37;
  localparam int LNMAG_W  = 39;
  localparam int QDIV_W   = 55;
  localparam int TK_W     = 16;
  localparam int SUM_W    = 57;
  localparam int SU_W     = 56;
  localparam int TC_W     = 17;

  // ln(2) in unsigned Q32.
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // One half in Q32, used to round the ln(2) product.
  localparam logic [64:0] HALF_Q32 = 65'd2147483648;
  // 100 * 2^48: the numerator of both reciprocals (centikelvin, Q48).
  localparam logic [SU_W-1:0] RECIP_NUM = 56'd100 << 48;

  localparam logic signed [16:0]       KELVIN_OFS = 17'sd27315;
  localparam logic [TC_W-1:0]          TC_MAX     = 17'd127315;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX   = 18'sd100000;
  localparam logic signed [TEMP_W-1:0] TEMP_ERR   = -18'sd27315;
  localparam logic signed [TEMP_W-1:0] KELVIN_OFS_T = 18'sd27315;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_BETA     = 2'd0,
    REG_REF_RES  = 2'd1,
    REG_REF_TEMP = 2'd2
  } cfg_reg_t;

endpackage

[design/tbc_if.sv]
interface tbc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] resistance_ohms;

  modport source (output valid, output resistance_ohms, input ready);
  modport sink   (input valid, input resistance_ohms, output ready);
endinterface

interface tbc_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] temp_centi;
  logic               error_flag;

  modport source (output valid, output temp_centi, output error_flag, input ready);
  modport sink   (input valid, input temp_centi, input error_flag, output ready);
endinterface

[design/tbc_log2_pipe.sv]
module tbc_log2_pipe #(
  parameter int W     = 16,
  parameter int TAG_W = 1
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       en,
  input  logic                                       in_valid,
  input  logic [TAG_W-1:0]                           in_tag,
  input  logic [W-1:0]                               x,
  output logic                                       out_valid,
  output logic [TAG_W-1:0]                           out_tag,
  output logic [$clog2(W)+tbc_pkg::FRAC_W-1:0]       log_q
);
  import tbc_pkg::*;

  localparam int EW = $clog2(W);

  logic [EW-1:0]        e_in;
  logic [W+MANT_FB-1:0] wide;

  logic [MANT_FB:0]   mant  [0:FRAC_W];
  logic [FRAC_W-1:0]  frac  [0:FRAC_W];
  logic [EW-1:0]      expo  [0:FRAC_W];
  logic [TAG_W-1:0]   tg    [0:FRAC_W];
  logic               vld   [0:FRAC_W];

  // Leading-one position and normalised mantissa in [1,2).
  always_comb begin
    e_in = '0;
    for (int i = 1; i < W; i++) begin
      if (x[i]) begin
        e_in = EW'(i);
      end
    end
  end

  assign wide = {x, {MANT_FB{1'b0}}} >> e_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mant[0] <= wide[MANT_FB:0];
      frac[0] <= '0;
      expo[0] <= e_in;
      tg[0]   <= in_tag;
    end
  end

  // One fraction bit per stage: square, and halve when the square reaches two.
  for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
    logic [2*MANT_FB+1:0] sq;
    logic                 ovr;

    assign sq  = mant[k] * mant[k];
    assign ovr = sq[2*MANT_FB+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mant[k+1] <= ovr ? sq[2*MANT_FB+1:MANT_FB+1] : sq[2*MANT_FB:MANT_FB];
        frac[k+1] <= {frac[k][FRAC_W-2:0], ovr};
        expo[k+1] <= expo[k];
        tg[k+1]   <= tg[k];
      end
    end
  end

  assign out_valid = vld[FRAC_W];
  assign out_tag   = tg[FRAC_W];
  assign log_q     = {expo[FRAC_W], frac[FRAC_W]};

endmodule

[design/tbc_div_pipe.sv]
module tbc_div_pipe #(
  parameter int NW    = 55,
  parameter int DW    = 16,
  parameter int QB    = 55,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [TAG_W-1:0] in_tag,
  input  logic [NW-1:0]    dividend,
  input  logic [DW-1:0]    divisor,
  output logic             out_valid,
  output logic [TAG_W-1:0] out_tag,
  output logic [QB-1:0]    quotient
);

  logic [DW+NW-1:0] ext;

  logic [DW-1:0]    rem [0:QB];
  logic [QB-1:0]    sh  [0:QB];
  logic [DW-1:0]    dv  [0:QB];
  logic [TAG_W-1:0] tg  [0:QB];
  logic             vld [0:QB];

  // The bits above the quotient seed the remainder; they must lie below the divisor.
  assign ext = {{DW{1'b0}}, dividend};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ext[QB +: DW];
      sh[0]  <= dividend[QB-1:0];
      dv[0]  <= divisor;
      tg[0]  <= in_tag;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    assign t    = {rem[k], sh[k][QB-1]};
    assign ge   = t >= {1'b0, dv[k]};
    assign diff = t - {1'b0, dv[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        sh[k+1]  <= {sh[k][QB-2:0], ge};
        dv[k+1]  <= dv[k];
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_tag   = tg[QB];
  assign quotient  = sh[QB];

endmodule

[design/thermistor_beta_to_celsius.sv]
// Thermistor Beta-equation converter. Each item on the sample channel is one
// measured resistance in ohms; the result channel returns the matching
// temperature in hundredths of a degree Celsius, solved from
// 1/T = 1/Tref + ln(R/Rref)/B, together with an error flag. The block is a
// fully pipelined datapath that takes one item in every cycle while the
// result side does not stall, and returns results in order. Its depth
// comes from the 32 squaring stages of the base-two logarithm units and
// the 55 stages of the restoring divider that forms ln/B, followed by the
// divider of the final reciprocal. A stall on the result channel freezes
// the whole pipe, so ready on the sample side follows the output register:
// it is high whenever that register is empty or being drained.
// Beta, the reference resistance and the reference temperature are written
// through the configuration port and are read live by the pipe, so they are
// to be changed only while no item is in flight. A zero beta, reference or
// resistance gives -273.15 C with the flag set; a non-positive reciprocal or
// a temperature above 1000 C gives 1000 C with the flag set.
module thermistor_beta_to_celsius (
  input  logic                          clk,
  input  logic                          rst,
  tbc_in_if.sink                        sample,
  tbc_out_if.source                     result,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tbc_pkg::CFG_W-1:0]     cfg_data
);
  import tbc_pkg::*;

  // Configuration registers.
  logic [BETA_W-1:0]        beta_value;
  logic [REF_W-1:0]         ref_resistance;
  logic signed [TREF_W-1:0] ref_temp_centi;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_value     <= BETA_W'(10);
      ref_resistance <= REF_W'(5000);
      ref_temp_centi <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BETA:     beta_value     <= cfg_data[BETA_W-1:0];
        REG_REF_RES:  ref_resistance <= cfg_data[REF_W-1:0];
        REG_REF_TEMP: ref_temp_centi <= cfg_data[TREF_W-1:0];
        default:      ;
      endcase
    end
  end

  // The whole pipe advances together unless a finished result is held.
  logic en;
  logic out_valid;

  assign en           = !out_valid || result.ready;
  assign sample.ready = en;

  logic in_fire;
  logic r_bad;
  logic cfg_bad;

  assign in_fire = sample.valid && en;
  assign r_bad   = sample.resistance_ohms == '0;
  assign cfg_bad = (beta_value == '0) || (ref_resistance == '0);

  // Base-two logarithms of the sample and of the reference resistance.
  localparam int LR_W   = $clog2(RES_W) + FRAC_W;
  localparam int LREF_W = $clog2(REF_W) + FRAC_W;

  logic [LR_W-1:0]   lr;
  logic [LREF_W-1:0] lref;
  logic              lr_valid;
  logic              lref_valid;
  logic              lr_bad;
  logic              lref_bad;

  tbc_log2_pipe #(.W(RES_W), .TAG_W(1)) u_log_r (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_fire),
    .in_tag    (r_bad),
    .x         (sample.resistance_ohms),
    .out_valid (lr_valid),
    .out_tag   (lr_bad),
    .log_q     (lr)
  );

  tbc_log2_pipe #(.W(REF_W), .TAG_W(1)) u_log_ref (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_fire),
    .in_tag    (cfg_bad),
    .x         (ref_resistance),
    .out_valid (lref_valid),
    .out_tag   (lref_bad),
    .log_q     (lref)
  );

  // Difference of the logarithms, held as sign and magnitude.
  logic [DMAG_W-1:0] lr_x;
  logic [DMAG_W-1:0] lref_x;
  logic              d_valid;
  logic              d_neg;
  logic              d_err;
  logic [DMAG_W-1:0] d_mag;

  assign lr_x   = DMAG_W'(lr);
  assign lref_x = DMAG_W'(lref);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= lr_valid && lref_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_neg <= lr_x < lref_x;
      d_mag <= (lr_x < lref_x) ? (lref_x - lr_x) : (lr_x - lref_x);
      d_err <= lr_bad || lref_bad;
    end
  end

  // Scale by ln(2): partial products of the low word and the integer part.
  logic        m1_valid;
  logic        m1_neg;
  logic        m1_err;
  logic [63:0] m1_lo;
  logic [DMAG_W-32+31:0] m1_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_lo  <= d_mag[31:0] * LN2_Q32;
      m1_hi  <= d_mag[DMAG_W-1:32] * LN2_Q32;
      m1_neg <= d_neg;
      m1_err <= d_err;
    end
  end

  logic [64:0]        lo_rnd;
  logic               m2_valid;
  logic               m2_neg;
  logic               m2_err;
  logic [LNMAG_W-1:0] m2_ln;

  assign lo_rnd = {1'b0, m1_lo} + HALF_Q32;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_ln  <= LNMAG_W'(m1_hi) + LNMAG_W'(lo_rnd[64:32]);
      m2_neg <= m1_neg;
      m2_err <= m1_err;
    end
  end

  // ln/B and 1/Tref, both in Q48 per kelvin, from two dividers in lockstep.
  logic [QDIV_W-1:0]   q_num;
  logic [QDIV_W-1:0]   i_num;
  logic signed [16:0]  tk_s;
  logic [TK_W-1:0]     tk;

  assign q_num = {m2_ln[QDIV_W-17:0], 16'b0} + QDIV_W'(beta_value >> 1);
  assign tk_s  = 17'(ref_temp_centi) + KELVIN_OFS;
  assign tk    = tk_s[TK_W-1:0];
  assign i_num = QDIV_W'(RECIP_NUM) + QDIV_W'(tk >> 1);

  logic              q_valid;
  logic              i_valid;
  logic              q_err;
  logic              i_neg;
  logic [QDIV_W-1:0] qmag;
  logic [QDIV_W-1:0] inv;

  tbc_div_pipe #(.NW(QDIV_W), .DW(BETA_W), .QB(QDIV_W), .TAG_W(1)) u_div_q (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .in_tag    (m2_err),
    .dividend  (q_num),
    .divisor   (beta_value),
    .out_valid (q_valid),
    .out_tag   (q_err),
    .quotient  (qmag)
  );

  tbc_div_pipe #(.NW(QDIV_W), .DW(TK_W), .QB(QDIV_W), .TAG_W(1)) u_div_i (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .in_tag    (m2_neg),
    .dividend  (i_num),
    .divisor   (tk),
    .out_valid (i_valid),
    .out_tag   (i_neg),
    .quotient  (inv)
  );

  // Reciprocal sum.
  logic [SUM_W-1:0] s_sum;
  logic             s_valid;
  logic             s_err;
  logic             s_nonpos;
  logic [SU_W-1:0]  s_mag;

  assign s_sum = i_neg ? (SUM_W'(inv) - SUM_W'(qmag)) : (SUM_W'(inv) + SUM_W'(qmag));

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= q_valid && i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_err    <= q_err;
      s_nonpos <= s_sum[SUM_W-1] || (s_sum == '0);
      s_mag    <= s_sum[SU_W-1:0];
    end
  end

  // Numerator of the final reciprocal, rounded half up.
  logic            p_valid;
  logic            p_err;
  logic            p_nonpos;
  logic [SU_W-1:0] p_num;
  logic [SU_W-1:0] p_su;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_num    <= RECIP_NUM + (s_mag >> 1);
      p_su     <= s_mag;
      p_err    <= s_err;
      p_nonpos <= s_nonpos;
    end
  end

  // Only seventeen quotient bits are formed; a larger quotient is out of range.
  logic             p_ovf;
  logic [2:0]       f_tag;
  logic             f_valid;
  logic [TC_W-1:0]  tc;

  assign p_ovf = SU_W'(p_num[SU_W-1:TC_W]) >= p_su;

  tbc_div_pipe #(.NW(SU_W), .DW(SU_W), .QB(TC_W), .TAG_W(3)) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p_valid),
    .in_tag    ({p_err, p_nonpos, p_ovf}),
    .dividend  (p_num),
    .divisor   (p_su),
    .out_valid (f_valid),
    .out_tag   (f_tag),
    .quotient  (tc)
  );

  // Output register: invalid inputs first, then saturation, then the value.
  logic                     f_sat;
  logic signed [TEMP_W-1:0] temp_val;
  logic                     flag_val;
  logic signed [TEMP_W-1:0] temp_centi;
  logic                     error_flag;

  assign f_sat = f_tag[1] || f_tag[0] || (tc > TC_MAX);

  always_comb begin
    if (f_tag[2]) begin
      temp_val = TEMP_ERR;
      flag_val = 1'b1;
    end else if (f_sat) begin
      temp_val = TEMP_MAX;
      flag_val = 1'b1;
    end else begin
      temp_val = signed'(TEMP_W'(tc)) - KELVIN_OFS_T;
      flag_val = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      temp_centi <= temp_val;
      error_flag <= flag_val;
    end
  end

  assign result.valid      = out_valid;
  assign result.temp_centi = temp_centi;
  assign result.error_flag = error_flag;

endmodule

[design/tbc_checker.sv]
module tbc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [17:0] temp_centi,
  input  logic        error_flag
);
  import tbc_pkg::*;

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temp_centi) && $stable(error_flag))
    else $error("result changed while stalled");

  // A clean result lies in the representable range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error_flag |->
      $signed(temp_centi) <= TEMP_MAX && $signed(temp_centi) >= TEMP_ERR)
    else $error("clean result out of range");

  // A flagged result carries one of the two sentinels.
  a_sentinel: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_flag |->
      $signed(temp_centi) == TEMP_MAX || $signed(temp_centi) == TEMP_ERR)
    else $error("flagged result is not a sentinel");

  // The sample side stalls exactly when a finished result is held.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("sample ready does not follow the output register");

  // Nothing comes out straight after reset.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind thermistor_beta_to_celsius tbc_checker u_tbc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (sample.ready),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .temp_centi (result.temp_centi),
  .error_flag (result.error_flag)
);
